// ===== hdl/rss_pkg.sv =====
// Shared constants, codes and control types of the stripe request splitter.
`default_nettype none
package rss_pkg;

	localparam int MAX_SUBDISKS = 16;
	localparam int SECTOR_BITS  = 48;
	localparam int SD_W         = $clog2(MAX_SUBDISKS);
	localparam int DCNT_W       = SD_W + 1;
	localparam int LEN_W        = 17;
	localparam int W_W          = LEN_W + SD_W;
	localparam int SDIV_W       = W_W + 1;
	localparam int SDIV_STEPS   = SD_W + 1;
	localparam int CNT_W        = $clog2(SECTOR_BITS);
	localparam int CFG_IDX_W    = 3;
	localparam int FL_W         = 5;
	localparam int FE_W         = 7;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRIPE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DCOUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLEX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DMASK  = 3'd4;

	localparam logic [LEN_W-1:0] RST_STRIPE = 17'd256;
	localparam logic [4:0]       RST_DCOUNT = 5'd3;
	localparam logic [4:0]       MIN_DCOUNT = 5'd3;

	// transfer flag bit positions
	localparam int FB_NR  = 0;
	localparam int FB_RR  = 1;
	localparam int FB_NW  = 2;
	localparam int FB_DW  = 3;
	localparam int FB_PW  = 4;
	localparam int FB_BAD = 5;
	localparam int FB_PAR = 6;

	localparam logic [FE_W-1:0] FM_DATAOP   = 7'b0010101;
	localparam logic [FE_W-1:0] FM_GROUPOP  = 7'b0001010;
	localparam logic [FE_W-1:0] FM_PARITYOP = 7'b0001110;

	typedef enum logic [1:0] {
		ROLE_PARITY = 2'd0,
		ROLE_DATA   = 2'd1,
		ROLE_RECOV  = 2'd2
	} role_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BEYOND = 2'd1,
		ST_SECOND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EK_PARITY = 2'd0,
		EK_DATA   = 2'd1,
		EK_RECOV  = 2'd2
	} ekind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_SDA,
		S_PREPA,
		S_PREPB,
		S_SDB,
		S_ADJ,
		S_SINIT,
		S_SCAN,
		S_EINIT,
		S_EMIT,
		S_ERR
	} state_t;

	typedef struct packed {
		logic    load;
		logic    div_init;
		logic    div_step;
		logic    sd_init;
		logic    sd_sel;
		logic    sd_step;
		logic    prep_a;
		logic    prep_b;
		logic    adj;
		logic    scan_init;
		logic    scan_step;
		logic    emit_init;
		logic    emit_step;
		logic    err_load;
		status_t err_code;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic beyond;
		logic second_down;
		logic scan_last;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/rss_ctrl.sv =====
// Sequencing state machine of the stripe request splitter.
`default_nettype none
module rss_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rss_pkg::sts_t sts,
	output rss_pkg::cmd_t      cmd
);
	import rss_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	status_t           code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.err_code = code_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.empty) begin
					state_d = S_IDLE;
				end else if (sts.beyond) begin
					code_d  = ST_BEYOND;
					state_d = S_ERR;
				end else begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SECTOR_BITS - 1)) begin
					cnt_d   = '0;
					state_d = S_SDA;
				end
			end
			S_SDA, S_SDB: begin
				cmd.sd_sel = (state_q == S_SDB);
				if (cnt_q == '0) cmd.sd_init = 1'b1;
				else cmd.sd_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SDIV_STEPS)) begin
					cnt_d   = '0;
					state_d = (state_q == S_SDA) ? S_PREPA : S_ADJ;
				end
			end
			S_PREPA: begin
				cmd.prep_a = 1'b1;
				state_d    = S_PREPB;
			end
			S_PREPB: begin
				cmd.prep_b = 1'b1;
				state_d    = S_SDB;
			end
			S_ADJ: begin
				cmd.adj = 1'b1;
				state_d = S_SINIT;
			end
			S_SINIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.second_down) begin
					code_d  = ST_SECOND;
					state_d = S_ERR;
				end else if (sts.scan_last) begin
					state_d = S_EINIT;
				end
			end
			S_EINIT: begin
				cmd.emit_init = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.emit_last) state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.err_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/rss_dp.sv =====
// Datapath: config registers, stripe divider, geometry, scan and element output register.
`default_nettype none
module rss_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	input  wire logic [rss_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]        cfg_data,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]        start_sector,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]        end_sector,
	input  wire logic                                   is_write,
	input  wire rss_pkg::cmd_t                          cmd,
	output rss_pkg::sts_t                               sts,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic [rss_pkg::SD_W-1:0]                    subdisk,
	output logic [rss_pkg::SECTOR_BITS-1:0]             subdisk_sector,
	output logic [rss_pkg::LEN_W-1:0]                   data_offset,
	output logic [rss_pkg::LEN_W-1:0]                   data_len,
	output logic [rss_pkg::LEN_W-1:0]                   group_offset,
	output logic [rss_pkg::LEN_W-1:0]                   group_len,
	output logic [1:0]                                  role,
	output logic [5:0]                                  xfer_flags,
	output logic                                        read_first,
	output logic [1:0]                                  status,
	output logic [rss_pkg::SECTOR_BITS-1:0]             next_sector,
	output logic                                        last_result
);
	import rss_pkg::*;

	// config
	logic [LEN_W-1:0]        stripe_q;
	logic [4:0]              dcount_q;
	logic                    rot_q;
	logic [SECTOR_BITS-1:0]  plex_q;
	logic [MAX_SUBDISKS-1:0] dmask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_q <= RST_STRIPE;
			dcount_q <= RST_DCOUNT;
			rot_q    <= 1'b1;
			plex_q   <= '0;
			dmask_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STRIPE: stripe_q <= cfg_data[LEN_W-1:0];
				CFG_DCOUNT: dcount_q <= cfg_data[4:0];
				CFG_ROTATE: rot_q    <= cfg_data[0];
				CFG_PLEX:   plex_q   <= cfg_data;
				CFG_DMASK:  dmask_q  <= cfg_data[MAX_SUBDISKS-1:0];
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0]  s_eff;
	logic [DCNT_W-1:0] d_eff;
	logic [SD_W-1:0]   dm1;

	always_comb begin
		s_eff = (stripe_q == '0) ? LEN_W'(1) : stripe_q;
		if (dcount_q < MIN_DCOUNT) d_eff = DCNT_W'(MIN_DCOUNT);
		else if (dcount_q > 5'(MAX_SUBDISKS)) d_eff = DCNT_W'(MAX_SUBDISKS);
		else d_eff = DCNT_W'(dcount_q);
		dm1 = SD_W'(d_eff - 1'b1);
	end

	function automatic logic [SD_W-1:0] skip_par(input logic [DCNT_W-1:0] sd,
		input logic [SD_W-1:0] psd, input logic [DCNT_W-1:0] d);
		logic [DCNT_W-1:0] t;
		t = sd;
		if (t == {1'b0, psd}) t = t + 1'b1;
		if (t >= d) t = '0;
		if (t == {1'b0, psd}) t = t + 1'b1;
		return t[SD_W-1:0];
	endfunction

	// request and working registers
	logic [SECTOR_BITS-1:0] start_q, end_q, dvd_q, base_q, len_q, next_q;
	logic                   wr_q;
	logic [W_W-1:0]         w_q, rem_q, ssec_q, rs_q;
	logic [SD_W-1:0]        pmod_q, psd_q, bad_q, sdc_q, dcnt_q, rcnt_q;
	logic [SDIV_W-1:0]      srem_q, sdv_q;
	logic [DCNT_W-1:0]      squo_q, first_q, sd_q;
	logic [LEN_W-1:0]       initoff_q, initlen_q, doff_q, dlen_q;
	logic [LEN_W-1:0]       goff_q, glen_q, woff_q, wlen_q;
	logic                   bad_v_q;
	logic [FL_W-1:0]        flags_q;
	ekind_t                 ekind_q;

	// long division step: remainder, quotient mod d, quotient times stripe size
	logic [W_W:0]           trial;
	logic                   qbit;
	logic [W_W-1:0]         rem_n;
	logic [DCNT_W-1:0]      pm_t;
	logic [SD_W-1:0]        pmod_n;
	logic [SECTOR_BITS-1:0] base_n;

	always_comb begin
		trial  = {rem_q, dvd_q[SECTOR_BITS-1]};
		qbit   = trial >= {1'b0, w_q};
		rem_n  = qbit ? W_W'(trial - {1'b0, w_q}) : trial[W_W-1:0];
		pm_t   = {pmod_q, qbit};
		pmod_n = (pm_t >= d_eff) ? SD_W'(pm_t - d_eff) : pm_t[SD_W-1:0];
		base_n = {base_q[SECTOR_BITS-2:0], 1'b0} +
			(qbit ? SECTOR_BITS'(s_eff) : '0);
	end

	// short division step
	logic sbit;
	assign sbit = srem_q >= sdv_q;

	// geometry helpers
	logic [SD_W-1:0]   psd_c;
	logic [W_W-1:0]    wrem;
	logic [LEN_W-1:0]  sfree;
	logic [W_W-1:0]    ssec_adj;
	logic [SD_W-1:0]   sdc_adj;
	logic              short_split;

	always_comb begin
		psd_c       = rot_q ? SD_W'(dm1 - pmod_q) : dm1;
		wrem        = w_q - rem_q;
		sfree       = s_eff - initoff_q;
		short_split = (squo_q > DCNT_W'(1)) && (ssec_q < W_W'(s_eff));
		ssec_adj    = short_split ? W_W'(initlen_q) : ssec_q;
		sdc_adj     = short_split ? SD_W'(1) : squo_q[SD_W-1:0];
	end

	// per-subdisk step shared by scan and emission
	logic [SD_W-1:0]  sk;
	logic             sk_down;
	logic [W_W-1:0]   rs_n;
	logic [LEN_W-1:0] dlen_n;
	logic [LEN_W:0]   hi_w, hi_d, hi;
	logic [LEN_W-1:0] wmin;
	logic [FL_W-1:0]  ffix;

	always_comb begin
		sk      = skip_par(sd_q, psd_q, d_eff);
		sk_down = dmask_q[sk];
		rs_n    = rs_q - W_W'(dlen_q);
		dlen_n  = (rs_n < W_W'(s_eff)) ? rs_n[LEN_W-1:0] : s_eff;
		hi_w    = {1'b0, woff_q} + {1'b0, wlen_q};
		hi_d    = {1'b0, doff_q} + {1'b0, dlen_q};
		hi      = (hi_w > hi_d) ? hi_w : hi_d;
		wmin    = (woff_q > doff_q) ? doff_q : woff_q;
		ffix    = flags_q;
		if (wr_q && bad_v_q && (bad_q == psd_q)) begin
			ffix[FB_NW] = 1'b0;
			ffix[FB_PW] = 1'b1;
		end
	end

	// element about to be emitted
	logic [FE_W-1:0]  e;
	logic [SD_W-1:0]  el_sd;
	role_t            el_role;
	logic             el_rf, el_last;
	logic [LEN_W-1:0] so, bdoff, bdlen, bgoff, bglen;

	always_comb begin
		e       = {2'b00, flags_q};
		el_sd   = sk;
		el_role = ROLE_DATA;
		el_rf   = 1'b1;
		el_last = 1'b0;
		case (ekind_q)
			EK_PARITY: begin
				e          = {2'b00, flags_q};
				e[FB_PAR]  = 1'b1;
				e[FB_NR]   = 1'b0;
				e[FB_PW]   = 1'b0;
				el_sd      = psd_q;
				el_role    = ROLE_PARITY;
			end
			EK_DATA: begin
				if (bad_v_q && (sk == bad_q)) begin
					e[FB_BAD] = 1'b1;
					e[FB_NR]  = 1'b0;
					e[FB_NW]  = 1'b0;
				end
				el_rf   = (|({2'b00, flags_q} & FM_PARITYOP)) && !e[FB_BAD];
				el_last = (dcnt_q == SD_W'(1)) && (rcnt_q == '0);
			end
			default: begin
				e       = {2'b00, flags_q} & ~FM_DATAOP;
				el_role = ROLE_RECOV;
				el_last = (rcnt_q == SD_W'(1));
			end
		endcase

		so    = goff_q;
		bdoff = '0;
		bdlen = '0;
		bgoff = '0;
		bglen = glen_q;
		if (e[FB_NW] && e[FB_PAR]) begin
			bdlen = wlen_q;
			if (e[FB_DW]) begin
				if (goff_q < woff_q) begin
					so    = goff_q;
					bdoff = woff_q - goff_q;
				end else begin
					so    = woff_q;
					bgoff = goff_q - woff_q;
				end
			end else begin
				so    = woff_q;
				bglen = '0;
			end
		end else if (|(e & FM_DATAOP)) begin
			bdlen = dlen_q;
			if (|(e & FM_GROUPOP)) begin
				if (goff_q < doff_q) begin
					so    = goff_q;
					bdoff = doff_q - goff_q;
				end else begin
					so    = doff_q;
					bgoff = goff_q - doff_q;
				end
			end else begin
				so    = doff_q;
				bglen = '0;
			end
		end
	end

	always_comb begin
		sts.empty       = start_q >= end_q;
		sts.beyond      = start_q >= plex_q;
		sts.second_down = sk_down && bad_v_q;
		sts.scan_last   = (rs_n == '0);
		sts.emit_last   = el_last;
		sts.out_free    = !out_valid || out_ready;
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_sector;
			end_q   <= end_sector;
			wr_q    <= is_write;
			w_q     <= W_W'(s_eff * dm1);
		end
		if (cmd.div_init) begin
			dvd_q  <= start_q;
			rem_q  <= '0;
			pmod_q <= '0;
			base_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q  <= {dvd_q[SECTOR_BITS-2:0], 1'b0};
			rem_q  <= rem_n;
			pmod_q <= pmod_n;
			base_q <= base_n;
		end
		if (cmd.sd_init) begin
			srem_q <= cmd.sd_sel ?
				SDIV_W'(ssec_q) + SDIV_W'(initoff_q) + SDIV_W'(s_eff) - SDIV_W'(1) :
				SDIV_W'(rem_q);
			sdv_q  <= SDIV_W'({s_eff, SD_W'(0)});
			squo_q <= '0;
		end
		if (cmd.sd_step) begin
			if (sbit) srem_q <= srem_q - sdv_q;
			squo_q <= {squo_q[DCNT_W-2:0], sbit};
			sdv_q  <= {1'b0, sdv_q[SDIV_W-1:1]};
		end
		if (cmd.prep_a) begin
			psd_q     <= psd_c;
			first_q   <= (squo_q >= {1'b0, psd_c}) ? squo_q + 1'b1 : squo_q;
			initoff_q <= srem_q[LEN_W-1:0];
			len_q     <= end_q - start_q;
		end
		if (cmd.prep_b) begin
			initlen_q <= (len_q < SECTOR_BITS'(sfree)) ? len_q[LEN_W-1:0] : sfree;
			ssec_q    <= (len_q < SECTOR_BITS'(wrem)) ? len_q[W_W-1:0] : wrem;
		end
		if (cmd.adj) begin
			ssec_q <= ssec_adj;
			sdc_q  <= sdc_adj;
			next_q <= start_q + SECTOR_BITS'(ssec_adj);
		end
		if (cmd.scan_init) begin
			sd_q    <= first_q;
			rs_q    <= ssec_q;
			doff_q  <= initoff_q;
			dlen_q  <= initlen_q;
			woff_q  <= initoff_q;
			wlen_q  <= '0;
			goff_q  <= '0;
			glen_q  <= '0;
			flags_q <= '0;
			bad_v_q <= dmask_q[psd_q];
			bad_q   <= psd_q;
		end
		if (cmd.scan_step) begin
			if (sk_down) begin
				bad_v_q <= 1'b1;
				bad_q   <= sk;
				goff_q  <= doff_q;
				glen_q  <= dlen_q;
				if (wr_q) flags_q[FB_DW] <= 1'b1;
				else flags_q[FB_RR] <= 1'b1;
			end else if (!wr_q) begin
				flags_q[FB_NR] <= 1'b1;
			end else begin
				flags_q[FB_NW] <= 1'b1;
				woff_q         <= wmin;
				wlen_q         <= LEN_W'(hi - {1'b0, wmin});
			end
			doff_q <= '0;
			rs_q   <= rs_n;
			dlen_q <= dlen_n;
			sd_q   <= {1'b0, sk} + 1'b1;
		end
		if (cmd.emit_init) begin
			flags_q <= ffix;
			doff_q  <= initoff_q;
			dlen_q  <= initlen_q;
			rs_q    <= ssec_q;
			sd_q    <= first_q;
			dcnt_q  <= sdc_q;
			rcnt_q  <= (|({2'b00, ffix} & FM_GROUPOP)) ? SD_W'(dm1 - sdc_q) : '0;
			ekind_q <= (|({2'b00, ffix} & FM_PARITYOP)) ? EK_PARITY : EK_DATA;
		end
		if (cmd.emit_step) begin
			case (ekind_q)
				EK_PARITY: ekind_q <= EK_DATA;
				EK_DATA: begin
					rs_q   <= rs_n;
					dlen_q <= dlen_n;
					doff_q <= '0;
					sd_q   <= {1'b0, sk} + 1'b1;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == SD_W'(1)) ekind_q <= EK_RECOV;
				end
				default: begin
					sd_q   <= {1'b0, sk} + 1'b1;
					rcnt_q <= rcnt_q - 1'b1;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_step || cmd.err_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			subdisk        <= el_sd;
			subdisk_sector <= base_q + SECTOR_BITS'(so);
			data_offset    <= bdoff;
			data_len       <= bdlen;
			group_offset   <= bgoff;
			group_len      <= bglen;
			role           <= el_role;
			xfer_flags     <= e[5:0];
			read_first     <= el_rf;
			status         <= ST_OK;
			next_sector    <= next_q;
			last_result    <= el_last;
		end else if (cmd.err_load) begin
			subdisk        <= '0;
			subdisk_sector <= '0;
			data_offset    <= '0;
			data_len       <= '0;
			group_offset   <= '0;
			group_len      <= '0;
			role           <= ROLE_PARITY;
			xfer_flags     <= '0;
			read_first     <= 1'b0;
			status         <= cmd.err_code;
			next_sector    <= start_q;
			last_result    <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/raid5_stripe_request_splitter.sv =====
// Top level of the RAID-5/RAID-4 stripe request splitter.
//
//  channel | beat fields                               | handshake
//  cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready (always ready)
//  in      | start_sector, end_sector, is_write        | in_valid / in_ready
//  out     | subdisk .. last_result (one element/beat) | out_valid / out_ready
//
// After a request beat the block runs the check, the bit-serial stripe divider
// (one quotient bit per cycle), two short divisions (load plus five quotient bits
// each) with set-up steps between and after them, a scan of each data unit in
// the stripe, emission set-up, and one element per cycle while out_ready stays
// high. Empty ranges return to idle straight from the check.
// Reset clears the controller and the output valid; config regs take their
// defaults. A stalled output holds the element in the output register and
// only emission and the error beat wait; a new request is taken once the
// last element is loaded.
`default_nettype none
module raid5_stripe_request_splitter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]      start_sector,
	input  wire logic [rss_pkg::SECTOR_BITS-1:0]      end_sector,
	input  wire logic                                 is_write,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [rss_pkg::SD_W-1:0]                  subdisk,
	output logic [rss_pkg::SECTOR_BITS-1:0]           subdisk_sector,
	output logic [rss_pkg::LEN_W-1:0]                 data_offset,
	output logic [rss_pkg::LEN_W-1:0]                 data_len,
	output logic [rss_pkg::LEN_W-1:0]                 group_offset,
	output logic [rss_pkg::LEN_W-1:0]                 group_len,
	output logic [1:0]                                role,
	output logic [5:0]                                xfer_flags,
	output logic                                      read_first,
	output logic [1:0]                                status,
	output logic [rss_pkg::SECTOR_BITS-1:0]           next_sector,
	output logic                                      last_result
);
	import rss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config writes land straight in registers
	assign cfg_ready = 1'b1;

	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start_sector   (start_sector),
		.end_sector     (end_sector),
		.is_write       (is_write),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.subdisk        (subdisk),
		.subdisk_sector (subdisk_sector),
		.data_offset    (data_offset),
		.data_len       (data_len),
		.group_offset   (group_offset),
		.group_len      (group_len),
		.role           (role),
		.xfer_flags     (xfer_flags),
		.read_first     (read_first),
		.status         (status),
		.next_sector    (next_sector),
		.last_result    (last_result)
	);

	// block goes busy after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after request beat");

	// error beats always close the request
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last_result)
		else $error("error beat not marked last");

	// parity element is never the final one
	a_parity_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) && (role == ROLE_PARITY) |-> !last_result)
		else $error("parity element marked last");

endmodule
`default_nettype wire
